[hdl/per_type_window_byte_budget_macros.svh]
// assertion macros shared by the budget filter modules
`ifndef PER_TYPE_WINDOW_BYTE_BUDGET_MACROS_SVH
`define PER_TYPE_WINDOW_BYTE_BUDGET_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, disabled during reset
`define PTWBB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication, disabled during reset
`define PTWBB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PTWBB_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define PTWBB_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

[hdl/ptwbb_pkg.sv]
`default_nettype none

package ptwbb_pkg;

   // table geometry
   localparam int TYPE_SLOTS = 1024;
   localparam int SLOT_BITS  = $clog2(TYPE_SLOTS);
   localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(TYPE_SLOTS - 1);

   // register indexes
   localparam int CSR_IDX_BITS = 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW_BUDGET = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HEADER_BYTES  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_TYPE      = 2'd2;
   localparam int CSR_DATA_BITS = 16;

   // register reset values
   localparam logic [15:0] WINDOW_BUDGET_RST = 16'd2048;
   localparam logic [7:0]  HEADER_BYTES_RST  = 8'd12;
   localparam logic [9:0]  MAX_TYPE_RST      = 10'd1023;

   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   // one table entry
   typedef struct packed {
      logic        valid;
      logic [15:0] budget;
      logic [31:0] wtime;
      logic [31:0] count;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   // controller to datapath commands
   typedef struct packed {
      logic                 accept;
      logic                 commit;
      logic                 clear;
      logic [SLOT_BITS-1:0] clear_addr;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

[hdl/ptwbb_if.sv]
`default_nettype none

// message channel
interface ptwbb_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] msg_type;
   logic [31:0] msg_time;
   logic [31:0] msg_length;
   modport source (output valid, msg_type, msg_time, msg_length, input ready);
   modport sink (input valid, msg_type, msg_time, msg_length, output ready);
endinterface

// verdict channel
interface ptwbb_rsp_if;
   logic        valid;
   logic        ready;
   logic        accepted;
   logic        ignored;
   logic [31:0] type_count;
   logic [15:0] budget_remaining;
   modport source (output valid, accepted, ignored, type_count, budget_remaining,
                   input ready);
   modport sink (input valid, accepted, ignored, type_count, budget_remaining,
                 output ready);
endinterface

// register write channel
interface ptwbb_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hdl/ptwbb_ram.sv]
`default_nettype none

module ptwbb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[hdl/ptwbb_ctrl.sv]
`default_nettype none
`include "per_type_window_byte_budget_macros.svh"

module ptwbb_ctrl
   import ptwbb_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output      logic     req_ready,
   input  wire stat_type stat,
   output      cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK
   } state_type;

   state_type            state_ff, state_in;
   logic [SLOT_BITS-1:0] clr_cnt_ff, clr_cnt_in;

   // next state
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == SLOT_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // command decode
   assign req_ready      = (state_ff == ST_IDLE);
   assign cmd.accept     = (state_ff == ST_IDLE) && req_valid;
   assign cmd.commit     = (state_ff == ST_LOOK) && stat.out_free;
   assign cmd.clear      = (state_ff == ST_CLEAR);
   assign cmd.clear_addr = clr_cnt_ff;

   `PTWBB_ASSERT_NEXT(a_clear_ends, clock, reset,
      (state_ff == ST_CLEAR) && (clr_cnt_ff == SLOT_LAST), state_ff == ST_IDLE,
      "table clear did not hand over to idle")
   `PTWBB_ASSERT_NEXT(a_look_follows_accept, clock, reset,
      cmd.accept, state_ff == ST_LOOK && !req_ready,
      "accepted transaction not followed by table lookup")

endmodule

`default_nettype wire

[hdl/ptwbb_dp.sv]
`default_nettype none
`include "per_type_window_byte_budget_macros.svh"

module ptwbb_dp
   import ptwbb_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cmd_type                  cmd,
   output      stat_type                 stat,
   input  wire logic [31:0]              msg_type,
   input  wire logic [31:0]              msg_time,
   input  wire logic [31:0]              msg_length,
   input  wire logic                     csr_valid,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_data,
   input  wire logic                     rsp_ready,
   output      logic                     rsp_valid,
   output      logic                     accepted,
   output      logic                     ignored,
   output      logic [31:0]              type_count,
   output      logic [15:0]              budget_remaining
);

   // configuration registers
   logic [15:0] window_budget_ff;
   logic [7:0]  header_bytes_ff;
   logic [9:0]  max_type_ff;

   // captured transaction
   logic [SLOT_BITS-1:0] slot_ff;
   logic [31:0]          now_ff;
   logic [32:0]          cost_ff;
   logic                 ignore_ff;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        accepted_ff;
   logic        ignored_ff;
   logic [31:0] count_ff;
   logic [15:0] budget_ff;

   // table ports
   logic [ENTRY_BITS-1:0] rd_data;
   entry_type             rd_entry;
   entry_type             new_entry;
   logic                  tbl_we;
   logic [SLOT_BITS-1:0]  tbl_waddr;
   logic [ENTRY_BITS-1:0] tbl_wdata;

   // evaluation
   logic        in_range;
   logic        same_window;
   logic        refill;
   logic [15:0] eff_budget;
   logic [31:0] eff_count;
   logic        drop;
   logic [15:0] spent_budget;
   logic [31:0] inc_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_budget_ff <= WINDOW_BUDGET_RST;
         header_bytes_ff  <= HEADER_BYTES_RST;
         max_type_ff      <= MAX_TYPE_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WINDOW_BUDGET: window_budget_ff <= csr_data;
            CSR_HEADER_BYTES:  header_bytes_ff  <= csr_data[7:0];
            CSR_MAX_TYPE:      max_type_ff      <= csr_data[9:0];
            default: ;
         endcase
      end
   end

   // range check and cost at acceptance
   assign in_range = (msg_type <= 32'(max_type_ff)) && (msg_type < 32'(TYPE_SLOTS));

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         slot_ff   <= msg_type[SLOT_BITS-1:0];
         now_ff    <= msg_time;
         cost_ff   <= {1'b0, msg_length} + 33'(header_bytes_ff);
         ignore_ff <= !in_range;
      end
   end

   ptwbb_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (TYPE_SLOTS)
   ) u_table (
      .clock (clock),
      .we    (tbl_we),
      .waddr (tbl_waddr),
      .wdata (tbl_wdata),
      .re    (cmd.accept),
      .raddr (msg_type[SLOT_BITS-1:0]),
      .rdata (rd_data)
   );

   assign rd_entry = rd_data;

   // budget decision; a fresh entry counts as the same window with a full budget
   assign same_window  = !rd_entry.valid || (rd_entry.wtime == now_ff);
   assign refill       = !rd_entry.valid || (rd_entry.wtime != now_ff);
   assign eff_budget   = refill ? window_budget_ff : rd_entry.budget;
   assign eff_count    = rd_entry.valid ? rd_entry.count : '0;
   assign drop         = same_window && ({17'd0, eff_budget} < cost_ff);
   assign spent_budget = ({17'd0, eff_budget} > cost_ff) ? eff_budget - cost_ff[15:0] : '0;
   assign inc_count    = (eff_count == COUNT_MAX) ? eff_count : eff_count + 1'b1;

   always_comb begin
      new_entry.valid  = 1'b1;
      new_entry.wtime  = now_ff;
      new_entry.budget = drop ? eff_budget : spent_budget;
      new_entry.count  = drop ? eff_count : inc_count;
   end

   // write-back or clear sweep
   assign tbl_we    = cmd.clear || (cmd.commit && !ignore_ff);
   assign tbl_waddr = cmd.clear ? cmd.clear_addr : slot_ff;
   assign tbl_wdata = cmd.clear ? '0 : new_entry;

   // response register
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         accepted_ff <= !ignore_ff && !drop;
         ignored_ff  <= ignore_ff;
         count_ff    <= ignore_ff ? '0 : new_entry.count;
         budget_ff   <= ignore_ff ? '0 : new_entry.budget;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign accepted         = accepted_ff;
   assign ignored          = ignored_ff;
   assign type_count       = count_ff;
   assign budget_remaining = budget_ff;

   `PTWBB_ASSERT_NOW(a_commit_needs_room, clock, reset,
      cmd.commit, !rsp_valid_ff || rsp_ready,
      "result committed over an untaken response")
   `PTWBB_ASSERT_NEXT(a_commit_shows, clock, reset,
      cmd.commit, rsp_valid_ff,
      "committed result not presented")
   `PTWBB_ASSERT_NOW(a_verdict_exclusive, clock, reset,
      rsp_valid_ff, !(accepted_ff && ignored_ff),
      "response both accepted and ignored")
   `PTWBB_ASSERT_NOW(a_no_clear_while_busy, clock, reset,
      cmd.clear, !cmd.accept && !cmd.commit,
      "table clear overlaps a transaction")

endmodule

`default_nettype wire

[hdl/per_type_window_byte_budget.sv]
// channel  | port    | direction | contents
// ---------+---------+-----------+------------------------------------------------
// message  | req_if  | in        | msg_type, msg_time, msg_length
// verdict  | rsp_if  | out       | accepted, ignored, type_count, budget_remaining
// config   | csr_if  | in        | index (0 budget, 1 header, 2 max type), data
//
// a transaction is accept with table read, then evaluate and write back; the registered
// table read must land before evaluation; no new message is taken until the write-back
// after reset the table is swept clear of all 1024 slots; req_if.ready stays low meanwhile
// a held response stalls only the write-back cycle; the next transaction is taken
// while a finished verdict waits; config writes are taken every cycle
`default_nettype none

module per_type_window_byte_budget
   import ptwbb_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   ptwbb_req_if.sink   req_if,
   ptwbb_rsp_if.source rsp_if,
   ptwbb_csr_if.sink   csr_if
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_if.ready = 1'b1;

   ptwbb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ptwbb_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .msg_type         (req_if.msg_type),
      .msg_time         (req_if.msg_time),
      .msg_length       (req_if.msg_length),
      .csr_valid        (csr_if.valid),
      .csr_index        (csr_if.index),
      .csr_data         (csr_if.data),
      .rsp_ready        (rsp_if.ready),
      .rsp_valid        (rsp_if.valid),
      .accepted         (rsp_if.accepted),
      .ignored          (rsp_if.ignored),
      .type_count       (rsp_if.type_count),
      .budget_remaining (rsp_if.budget_remaining)
   );

endmodule

`default_nettype wire

[tb/ptwbb_checker.sv]
`default_nettype none

module ptwbb_checker
   import ptwbb_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   ptwbb_req_if        req_if,
   ptwbb_rsp_if        rsp_if,
   ptwbb_csr_if        csr_if,
   output int unsigned fail_count,
   output int unsigned verdicts_due
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        accepted;
      logic        ignored;
      logic [31:0] type_count;
      logic [15:0] budget_remaining;
   } verdict_type;

   verdict_type verdict_q[$];

   // register shadows
   logic [15:0] cfg_budget;
   logic [7:0]  cfg_header;
   logic [9:0]  cfg_max_type;

   // per-type table shadow
   logic        slot_seen   [TYPE_SLOTS];
   logic [15:0] slot_budget [TYPE_SLOTS];
   logic [31:0] slot_wtime  [TYPE_SLOTS];
   logic [31:0] slot_count  [TYPE_SLOTS];

   initial begin
      fail_count   = 0;
      verdicts_due = 0;
   end

   // judge one message against its type's window and update the table shadow
   function automatic verdict_type judge_msg(logic [31:0] mtype, logic [31:0] mtime,
                                             logic [31:0] mlen);
      verdict_type          v;
      logic [32:0]          cost;
      logic [SLOT_BITS-1:0] slot;
      v    = '0;
      cost = {1'b0, mlen} + 33'(cfg_header);
      if (mtype > 32'(cfg_max_type) || mtype >= 32'(TYPE_SLOTS)) begin
         v.ignored = 1'b1;
         return v;
      end
      slot = mtype[SLOT_BITS-1:0];
      // first sighting opens a window at this message's time
      if (!slot_seen[slot]) begin
         slot_seen[slot]   = 1'b1;
         slot_budget[slot] = cfg_budget;
         slot_wtime[slot]  = mtime;
         slot_count[slot]  = '0;
      end
      if (slot_wtime[slot] == mtime && 33'(slot_budget[slot]) < cost) begin
         v.accepted = 1'b0;
      end else begin
         // refill on a new window, then charge with saturation at zero
         if (slot_wtime[slot] != mtime) begin
            slot_budget[slot] = cfg_budget;
            slot_wtime[slot]  = mtime;
         end
         if (33'(slot_budget[slot]) > cost)
            slot_budget[slot] = slot_budget[slot] - cost[15:0];
         else
            slot_budget[slot] = '0;
         if (slot_count[slot] != COUNT_MAX)
            slot_count[slot] = slot_count[slot] + 32'd1;
         v.accepted = 1'b1;
      end
      v.type_count       = slot_count[slot];
      v.budget_remaining = slot_budget[slot];
      return v;
   endfunction

   // watch all three channels
   always @(posedge clock) begin
      verdict_type exp_v;
      verdict_type got_v;
      if (reset) begin
         cfg_budget   = WINDOW_BUDGET_RST;
         cfg_header   = HEADER_BYTES_RST;
         cfg_max_type = MAX_TYPE_RST;
         for (int i = 0; i < TYPE_SLOTS; i++)
            slot_seen[i] = 1'b0;
         verdict_q.delete();
      end else begin
         // register writes
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               CSR_WINDOW_BUDGET: cfg_budget   = csr_if.data;
               CSR_HEADER_BYTES:  cfg_header   = csr_if.data[7:0];
               CSR_MAX_TYPE:      cfg_max_type = csr_if.data[9:0];
               default: ;
            endcase
         end
         // verdict transaction against the oldest expectation
         if (rsp_if.valid && rsp_if.ready) begin
            got_v = '{rsp_if.accepted, rsp_if.ignored, rsp_if.type_count,
                      rsp_if.budget_remaining};
            if (verdict_q.size() == 0) begin
               $display("%0t: verdict with none expected: acc=%0b ign=%0b cnt=%0d bud=%0d",
                        $time, got_v.accepted, got_v.ignored, got_v.type_count,
                        got_v.budget_remaining);
               fail_count++;
            end else begin
               exp_v = verdict_q.pop_front();
               if (got_v !== exp_v) begin
                  $display("%0t: verdict mismatch: expected acc=%0b ign=%0b cnt=%0d bud=%0d",
                           $time, exp_v.accepted, exp_v.ignored, exp_v.type_count,
                           exp_v.budget_remaining);
                  $display("%0t:                     actual acc=%0b ign=%0b cnt=%0d bud=%0d",
                           $time, got_v.accepted, got_v.ignored, got_v.type_count,
                           got_v.budget_remaining);
                  fail_count++;
               end
            end
         end
         // message transaction, appended behind the pending expectations
         if (req_if.valid && req_if.ready)
            verdict_q.insert(verdict_q.size(), judge_msg(req_if.msg_type, req_if.msg_time,
                                                         req_if.msg_length));
      end
      verdicts_due = verdict_q.size();
   end

endmodule

`default_nettype wire

[tb/tb_top.sv]
`default_nettype none

module tb_top;
   import ptwbb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASES = 6;

   // register settings per phase; the first phase keeps the reset values
   localparam logic [15:0] PHASE_BUDGET [PHASES] = '{16'd2048, 16'd0, 16'hFFFF,
                                                      16'd500, 16'd1000, 16'd3000};
   localparam logic [15:0] PHASE_HEADER [PHASES] = '{16'd12, 16'd0, 16'd255,
                                                      16'hAB28, 16'd0, 16'd12};
   localparam logic [15:0] PHASE_MAXT   [PHASES] = '{16'd1023, 16'd0, 16'd1023,
                                                      16'hFC09, 16'd512, 16'd1023};
   localparam int          PHASE_MSGS   [PHASES] = '{200, 120, 220, 200, 200, 160};

   logic clock;
   logic reset;

   ptwbb_req_if req_if ();
   ptwbb_rsp_if rsp_if ();
   ptwbb_csr_if csr_if ();

   int unsigned fail_count;
   int unsigned verdicts_due;

   // stimulus shaping state
   logic [31:0] now_stamp;
   int          cur_budget;
   int          cur_max;
   int          msgs_sent;

   per_type_window_byte_budget u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   ptwbb_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_if       (req_if),
      .rsp_if       (rsp_if),
      .csr_if       (csr_if),
      .fail_count   (fail_count),
      .verdicts_due (verdicts_due)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // mostly short gaps, a few long ones, none during steady stretches
   function automatic int pause_len(bit steady);
      int r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // offer one message after a random gap and wait for its transaction
   task automatic offer_msg(logic [31:0] mtype, logic [31:0] mtime, logic [31:0] mlen);
      int gap;
      gap = pause_len((msgs_sent / 130) % 3 == 2);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.msg_type   <= mtype;
      req_if.msg_time   <= mtime;
      req_if.msg_length <= mlen;
      do @(posedge clock); while (!req_if.ready);
      msgs_sent++;
   endtask

   // mostly bursts on a few hot types in the current window, then spread and noise
   task automatic random_msg();
      int          pick;
      int          hot;
      logic [31:0] mtype;
      logic [31:0] mtime;
      logic [31:0] mlen;
      hot  = (cur_max < 14) ? cur_max + 2 : 15;
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
         mtype = $urandom_range(0, hot);
         if ($urandom_range(0, 9) == 0)
            mtype = $urandom_range(0, 1023);
         pick = $urandom_range(0, 99);
         if (pick < 12)
            now_stamp = now_stamp + $urandom_range(1, 3);
         else if (pick < 15)
            now_stamp = $urandom;
         mtime = now_stamp;
         mlen  = $urandom_range(0, cur_budget / 4 + 20);
      end else if (pick < 90) begin
         mtype = ($urandom_range(0, 3) == 0) ? 32'(cur_max + 1) : $urandom_range(0, 1023);
         mtime = now_stamp;
         mlen  = $urandom;
      end else begin
         mtype = $urandom;
         mtime = $urandom;
         mlen  = $urandom_range(0, 64);
      end
      offer_msg(mtype, mtime, mlen);
   endtask

   // one register write transaction, valid left high for the caller
   task automatic put_reg(logic [CSR_IDX_BITS-1:0] idx, logic [15:0] val);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      do @(posedge clock); while (!csr_if.ready);
   endtask

   // wait for all verdicts, then rewrite every register
   task automatic set_config(int ph);
      req_if.valid <= 1'b0;
      do @(negedge clock); while (verdicts_due != 0);
      @(posedge clock);
      put_reg(CSR_WINDOW_BUDGET, PHASE_BUDGET[ph]);
      put_reg(CSR_HEADER_BYTES, PHASE_HEADER[ph]);
      put_reg(CSR_MAX_TYPE, PHASE_MAXT[ph]);
      csr_if.valid <= 1'b0;
      cur_budget = PHASE_BUDGET[ph];
      cur_max    = PHASE_MAXT[ph] & 16'h03FF;
   endtask

   // message source and verdict
   initial begin
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.msg_type   = '0;
      req_if.msg_time   = '0;
      req_if.msg_length = '0;
      csr_if.valid      = 1'b0;
      csr_if.index      = CSR_WINDOW_BUDGET;
      csr_if.data       = '0;
      now_stamp         = 32'd200;
      cur_budget        = WINDOW_BUDGET_RST;
      cur_max           = MAX_TYPE_RST;
      msgs_sent         = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: draining to zero, refills, oversize costs, out of range types
      offer_msg(32'd0, 32'd0, 32'd0);
      offer_msg(32'd0, 32'd0, 32'd2024);
      offer_msg(32'd0, 32'd0, 32'd0);
      offer_msg(32'd0, 32'd1, 32'hFFFF_FFFF);
      offer_msg(32'd0, 32'd1, 32'd0);
      offer_msg(32'd1023, 32'hFFFF_FFFF, 32'd100);
      offer_msg(32'd1023, 32'hFFFF_FFFF, 32'd1924);
      offer_msg(32'd1024, 32'd5, 32'd5);
      offer_msg(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      offer_msg(32'd5, 32'd7, 32'hFFFF_FFFF);
      offer_msg(32'd5, 32'd7, 32'd0);
      offer_msg(32'd5, 32'd8, 32'd2036);
      offer_msg(32'd2, 32'd0, 32'd2037);
      offer_msg(32'd2, 32'd0, 32'd2036);
      offer_msg(32'd3, 32'd100, 32'hFFFF_FFF4);
      offer_msg(32'd3, 32'd101, 32'hFFFF_FFF4);
      offer_msg(32'd512, 32'd3, 32'hAAAA_5555);
      offer_msg(32'h8000_03FF, 32'h5555_AAAA, 32'd1);

      // random phases across register settings
      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph != 0)
            set_config(ph);
         if (ph == 1) begin
            // zero budget and header: only zero-length messages fit, unless one opens a new window of a seen type
            offer_msg(32'd0, now_stamp, 32'd0);
            offer_msg(32'd0, now_stamp, 32'd1);
            offer_msg(32'd1, now_stamp, 32'd0);
         end
         for (int n = 0; n < PHASE_MSGS[ph]; n++)
            random_msg();
      end
      req_if.valid <= 1'b0;

      // drain, then allow time for stray verdicts
      do @(negedge clock); while (verdicts_due != 0);
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // verdict sink with random stalls and one long hold-off
   initial begin
      int gap;
      int taken;
      rsp_if.ready = 1'b0;
      taken        = 0;
      wait (!reset);
      forever begin
         gap = pause_len((taken / 150) % 2 == 1);
         if (gap != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         taken++;
         // hold off long enough for the input side to back up
         if (taken == 100) begin
            rsp_if.ready <= 1'b0;
            repeat (400) @(posedge clock);
         end
      end
   end

   // run limit
   initial begin
      #10ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

`default_nettype wire
